>>> rtl/core/esd_pkg.sv
package esd_pkg;

  localparam logic [7:0] CharBackslash = 8'h5C;
  localparam logic [7:0] CharPercent   = 8'h25;
  localparam logic [7:0] CharHexMark   = 8'h78;  // 'x'
  localparam logic [7:0] CharEscape    = 8'o033;
  localparam logic [7:0] ByteMax       = 8'd255;
  localparam logic [1:0] OctDigitsMax  = 2'd3;

  localparam logic ErrKindNullEsc    = 1'b0;
  localparam logic ErrKindInvalidEsc = 1'b1;

  typedef struct packed {
    logic [7:0] data;
    logic       pct;
    logic       err;
    logic       kind;
    logic       last;
  } res_t;

  // Returns the decoded value of a named escape, or zero if c names none.
  function automatic logic [7:0] named_escape(input logic [7:0] c);
    logic [7:0] v;
    v = 8'd0;
    unique case (c) inside
      8'h22, 8'h27, 8'h5C: v = c;
      8'h61:               v = 8'd7;
      8'h62:               v = 8'd8;
      8'h65, 8'h45:        v = CharEscape;
      8'h66:               v = 8'd12;
      8'h6E:               v = 8'd10;
      8'h72:               v = 8'd13;
      8'h74:               v = 8'd9;
      8'h76:               v = 8'd11;
      default:             v = 8'd0;
    endcase
    return v;
  endfunction

  // Bit 4 flags a valid hex digit, bits 3:0 carry its value.
  function automatic logic [4:0] hex_digit(input logic [7:0] c);
    logic [4:0] h;
    h = 5'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      h = {1'b1, c[3:0]};
    end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
      h = {1'b1, c[3:0] + 4'd9};
    end
    return h;
  endfunction

  function automatic logic is_oct_digit(input logic [7:0] c);
    return c[7:3] == 5'b00110;
  endfunction

  function automatic logic [7:0] saturate(input logic [8:0] a);
    return a[8] ? ByteMax : a[7:0];
  endfunction

  function automatic res_t data_res(input logic [7:0] d, input logic pct, input logic last);
    res_t r;
    r.data = d;
    r.pct  = pct;
    r.err  = 1'b0;
    r.kind = 1'b0;
    r.last = last;
    return r;
  endfunction

  function automatic res_t err_res(input logic kind, input logic last);
    res_t r;
    r.data = 8'd0;
    r.pct  = 1'b0;
    r.err  = 1'b1;
    r.kind = kind;
    r.last = last;
    return r;
  endfunction

endpackage

>>> rtl/core/escape_sequence_decoder.sv
// Streaming decoder for C-style backslash escapes.
// Input channel: one raw string byte per request (in_byte_i), with in_last_i
// on the final byte of a string. Output channel: decoded bytes, each with a
// percent flag, an error flag and kind, and out_last_o on the final result
// that the final byte causes.
// Each request is decoded in the cycle it is accepted and its zero, one or
// two results are written into a three-entry result queue; the first result
// is on the output in the cycle after acceptance if the queue was empty. A
// request is accepted in every cycle while the queue holds at most one
// result, so the sustained rate is one byte per cycle. A byte that ends an
// octal or hex escape and yields its own byte adds two results at once.
// After an escape error the rest of the string is discarded without results.
// While the receiver stalls, the queue fills and in_stall_o rises once two
// or more results wait. Reset empties the queue, clears the decoder state
// and the discard flag, and puts the decoder in plain-text mode.
module escape_sequence_decoder
  import esd_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] in_byte_i,
  input  logic       in_last_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] out_byte_o,
  output logic       is_percent_o,
  output logic       err_o,
  output logic       err_kind_o,
  output logic       out_last_o
);

  typedef enum logic [2:0] {
    MODE_IDLE,
    MODE_ESC,
    MODE_OCT,
    MODE_HEX0,
    MODE_HEX1
  } mode_e;

  mode_e      mode_q, mode_d;
  logic [8:0] accum_q, accum_d;
  logic [1:0] digits_q, digits_d;
  logic       skip_q, skip_d;

  res_t       queue_q [3];
  logic [1:0] wr_ptr_q, rd_ptr_q;
  logic [1:0] count_q;

  res_t       res0, res1;
  logic [1:0] n_res;
  logic       in_acc, out_acc;
  logic       any_err;

  function automatic logic [1:0] ptr_inc(input logic [1:0] p);
    return (p == 2'd2) ? 2'd0 : p + 2'd1;
  endfunction

  assign in_stall_o  = count_q >= 2'd2;
  assign in_acc      = in_valid_i && !in_stall_o;
  assign out_valid_o = count_q != 2'd0;
  assign out_acc     = out_valid_o && !out_stall_i;

  always_comb begin
    logic [4:0] hx;
    logic [7:0] nv;
    logic [8:0] acc;
    logic       do_plain;
    logic       plain_slot;
    logic [1:0] dig;
    hx         = hex_digit(in_byte_i);
    nv         = named_escape(in_byte_i);
    acc        = 9'd0;
    dig        = 2'd0;
    do_plain   = 1'b0;
    plain_slot = 1'b0;
    mode_d     = mode_q;
    accum_d    = accum_q;
    digits_d   = digits_q;
    skip_d     = skip_q;
    n_res      = 2'd0;
    res0       = data_res(8'd0, 1'b0, 1'b0);
    res1       = data_res(8'd0, 1'b0, 1'b0);

    if (skip_q) begin
      if (in_last_i) begin
        skip_d   = 1'b0;
        mode_d   = MODE_IDLE;
        accum_d  = 9'd0;
        digits_d = 2'd0;
      end
    end else begin
      unique case (mode_q)
        MODE_ESC: begin
          mode_d   = MODE_IDLE;
          accum_d  = 9'd0;
          digits_d = 2'd0;
          if (nv != 8'd0) begin
            res0  = data_res(nv, 1'b0, in_last_i);
            n_res = 2'd1;
          end else if (is_oct_digit(in_byte_i)) begin
            if (in_last_i) begin
              res0  = data_res({5'd0, in_byte_i[2:0]}, 1'b0, 1'b1);
              n_res = 2'd1;
            end else begin
              mode_d   = MODE_OCT;
              accum_d  = {6'd0, in_byte_i[2:0]};
              digits_d = 2'd1;
            end
          end else if (in_byte_i == CharHexMark && !in_last_i) begin
            mode_d = MODE_HEX0;
          end else begin
            res0   = err_res(ErrKindInvalidEsc, in_last_i);
            n_res  = 2'd1;
            skip_d = !in_last_i;
          end
        end
        MODE_OCT: begin
          if (is_oct_digit(in_byte_i)) begin
            acc = {accum_q[5:0], in_byte_i[2:0]};
            dig = digits_q + 2'd1;
            if (dig >= OctDigitsMax || in_last_i) begin
              res0     = data_res(saturate(acc), 1'b0, in_last_i);
              n_res    = 2'd1;
              mode_d   = MODE_IDLE;
              accum_d  = 9'd0;
              digits_d = 2'd0;
            end else begin
              accum_d  = acc;
              digits_d = dig;
            end
          end else begin
            res0       = data_res(saturate(accum_q), 1'b0, 1'b0);
            n_res      = 2'd1;
            mode_d     = MODE_IDLE;
            accum_d    = 9'd0;
            digits_d   = 2'd0;
            do_plain   = 1'b1;
            plain_slot = 1'b1;
          end
        end
        MODE_HEX0: begin
          if (!hx[4]) begin
            res0     = err_res(ErrKindInvalidEsc, in_last_i);
            n_res    = 2'd1;
            skip_d   = !in_last_i;
            mode_d   = MODE_IDLE;
            accum_d  = 9'd0;
            digits_d = 2'd0;
          end else if (in_last_i) begin
            res0     = data_res({4'd0, hx[3:0]}, 1'b0, 1'b1);
            n_res    = 2'd1;
            mode_d   = MODE_IDLE;
            accum_d  = 9'd0;
            digits_d = 2'd0;
          end else begin
            mode_d  = MODE_HEX1;
            accum_d = {5'd0, hx[3:0]};
          end
        end
        MODE_HEX1: begin
          mode_d   = MODE_IDLE;
          accum_d  = 9'd0;
          digits_d = 2'd0;
          if (hx[4]) begin
            acc   = {accum_q[4:0], hx[3:0]};
            res0  = data_res(saturate(acc), 1'b0, in_last_i);
            n_res = 2'd1;
          end else begin
            res0       = data_res(saturate(accum_q), 1'b0, 1'b0);
            n_res      = 2'd1;
            do_plain   = 1'b1;
            plain_slot = 1'b1;
          end
        end
        default: begin
          mode_d   = MODE_IDLE;
          accum_d  = 9'd0;
          digits_d = 2'd0;
          do_plain = 1'b1;
        end
      endcase

      // Plain-text handling of the byte, either on its own or after a flush.
      if (do_plain) begin
        if (in_byte_i == CharBackslash && !in_last_i) begin
          mode_d = MODE_ESC;
        end else begin
          if (in_byte_i == CharBackslash) begin
            res1 = err_res(ErrKindNullEsc, 1'b1);
          end else begin
            res1 = data_res(in_byte_i, in_byte_i == CharPercent, in_last_i);
          end
          if (plain_slot) begin
            n_res = 2'd2;
          end else begin
            res0  = res1;
            n_res = 2'd1;
          end
        end
      end
    end
  end

  assign any_err = (n_res != 2'd0) && (res0.err || (n_res == 2'd2 && res1.err));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= MODE_IDLE;
      accum_q  <= 9'd0;
      digits_q <= 2'd0;
      skip_q   <= 1'b0;
      wr_ptr_q <= 2'd0;
      rd_ptr_q <= 2'd0;
      count_q  <= 2'd0;
    end else begin
      if (in_acc) begin
        mode_q   <= mode_d;
        accum_q  <= accum_d;
        digits_q <= digits_d;
        skip_q   <= skip_d;
        if (n_res == 2'd1) begin
          wr_ptr_q <= ptr_inc(wr_ptr_q);
        end else if (n_res == 2'd2) begin
          wr_ptr_q <= ptr_inc(ptr_inc(wr_ptr_q));
        end
      end
      if (out_acc) begin
        rd_ptr_q <= ptr_inc(rd_ptr_q);
      end
      count_q <= count_q + (in_acc ? n_res : 2'd0) - {1'b0, out_acc};
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc && n_res != 2'd0) begin
      queue_q[wr_ptr_q] <= res0;
    end
    if (in_acc && n_res == 2'd2) begin
      queue_q[ptr_inc(wr_ptr_q)] <= res1;
    end
  end

  assign out_byte_o   = queue_q[rd_ptr_q].data;
  assign is_percent_o = queue_q[rd_ptr_q].pct;
  assign err_o        = queue_q[rd_ptr_q].err;
  assign err_kind_o   = queue_q[rd_ptr_q].kind;
  assign out_last_o   = queue_q[rd_ptr_q].last;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q != 2'd3 || in_stall_o)
    else $error("result queue overfilled");

  a_skip_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skip_q |-> mode_q == MODE_IDLE)
    else $error("discarding while an escape is pending");

  a_err_skip: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && any_err && !in_last_i) |=> skip_q)
    else $error("error inside a string did not start discarding");

  a_skip_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && skip_q) |-> n_res == 2'd0)
    else $error("result produced while discarding");

  a_ptr_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_ptr_q != 2'd3 && rd_ptr_q != 2'd3)
    else $error("queue pointer out of range");

endmodule

>>> tb/testbench.sv
`timescale 1ns / 100ps

module testbench;
  import esd_pkg::*;

  typedef enum logic [2:0] {
    DecPlain,
    DecEscape,
    DecOctal,
    DecHexFirst,
    DecHexNext
  } dec_mode_e;

  localparam int CycleLimit  = 200000;
  localparam int LiveTarget  = 450;
  localparam int CalmAfter   = 410;
  localparam int DrainCycles = 8;

  class escape_scoreboard;
    dec_mode_e  mode;
    logic [8:0] accum;
    logic [1:0] digits;
    logic       skipping;
    res_t       awaited[$];
    int         mismatches;
    int         live;

    function new();
      mode       = DecPlain;
      accum      = '0;
      digits     = '0;
      skipping   = 1'b0;
      mismatches = 0;
      live       = 0;
    endfunction

    function void to_plain();
      mode   = DecPlain;
      accum  = '0;
      digits = '0;
    endfunction

    function void emit(logic [7:0] d, logic p, logic e, logic k, logic l);
      res_t r;
      r.data = d;
      r.pct  = p;
      r.err  = e;
      r.kind = k;
      r.last = l;
      awaited.push_back(r);
    endfunction

    // An error ends the string; unless it came on the final byte, the rest is dropped.
    function void escape_error(logic k, logic l);
      to_plain();
      skipping = !l;
      emit(8'd0, 1'b0, 1'b1, k, l);
    endfunction

    function void take_plain(logic [7:0] c, logic l);
      if (c == CharBackslash) begin
        if (l) begin
          escape_error(ErrKindNullEsc, 1'b1);
        end else begin
          mode = DecEscape;
        end
      end else begin
        emit(c, c == CharPercent, 1'b0, 1'b0, l);
      end
    endfunction

    function void flush_value(logic l);
      logic [7:0] v;
      v = (accum > 9'd255) ? ByteMax : accum[7:0];
      to_plain();
      emit(v, 1'b0, 1'b0, 1'b0, l);
    endfunction

    function logic [7:0] named_code(logic [7:0] c);
      case (c)
        8'h22, 8'h27, CharBackslash: return c;
        "a":      return 8'd7;
        "b":      return 8'd8;
        "e", "E": return CharEscape;
        "f":      return 8'd12;
        "n":      return 8'd10;
        "r":      return 8'd13;
        "t":      return 8'd9;
        "v":      return 8'd11;
        default:  return 8'd0;
      endcase
    endfunction

    function int hex_of(logic [7:0] c);
      if (c >= "0" && c <= "9") return int'(c - "0");
      if (c >= "a" && c <= "f") return int'(c - "a") + 10;
      if (c >= "A" && c <= "F") return int'(c - "A") + 10;
      return -1;
    endfunction

    function void note_request(logic [7:0] c, logic l);
      logic [7:0] v;
      int         h;
      live++;
      if (skipping) begin
        if (l) begin
          skipping = 1'b0;
          to_plain();
        end
        return;
      end
      case (mode)
        DecEscape: begin
          v = named_code(c);
          if (v != 8'd0) begin
            to_plain();
            emit(v, 1'b0, 1'b0, 1'b0, l);
          end else if (c >= "0" && c <= "7") begin
            mode   = DecOctal;
            accum  = {1'b0, c - 8'h30};
            digits = 2'd1;
            if (l) flush_value(1'b1);
          end else if (c == CharHexMark && !l) begin
            mode  = DecHexFirst;
            accum = '0;
          end else begin
            escape_error(ErrKindInvalidEsc, l);
          end
        end
        DecOctal: begin
          if (c >= "0" && c <= "7") begin
            accum  = accum * 9'd8 + {1'b0, c - 8'h30};
            digits = digits + 2'd1;
            if (digits >= OctDigitsMax || l) flush_value(l);
          end else begin
            flush_value(1'b0);
            take_plain(c, l);
          end
        end
        DecHexFirst: begin
          h = hex_of(c);
          if (h < 0) begin
            escape_error(ErrKindInvalidEsc, l);
          end else begin
            accum = 9'(h);
            mode  = DecHexNext;
            if (l) flush_value(1'b1);
          end
        end
        DecHexNext: begin
          h = hex_of(c);
          if (h >= 0) begin
            accum = accum * 9'd16 + 9'(h);
            flush_value(l);
          end else begin
            flush_value(1'b0);
            take_plain(c, l);
          end
        end
        default: begin
          to_plain();
          take_plain(c, l);
        end
      endcase
    endfunction

    function void check_result(res_t got);
      res_t want;
      if (awaited.size() == 0) begin
        $error("unexpected result: out_byte %0d err %0b", got.data, got.err);
        mismatches++;
        return;
      end
      want = awaited.pop_front();
      if (got.data !== want.data) begin
        $error("out_byte: expected %0d, got %0d", want.data, got.data);
        mismatches++;
      end
      if (got.pct !== want.pct) begin
        $error("is_percent: expected %0b, got %0b", want.pct, got.pct);
        mismatches++;
      end
      if (got.err !== want.err) begin
        $error("err: expected %0b, got %0b", want.err, got.err);
        mismatches++;
      end
      if (got.kind !== want.kind) begin
        $error("err_kind: expected %0b, got %0b", want.kind, got.kind);
        mismatches++;
      end
      if (got.last !== want.last) begin
        $error("out_last: expected %0b, got %0b", want.last, got.last);
        mismatches++;
      end
    endfunction
  endclass

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       in_valid_i = 1'b0;
  logic       in_stall_o;
  logic [7:0] in_byte_i = 8'd0;
  logic       in_last_i = 1'b0;
  logic       out_valid_o;
  logic       out_stall_i = 1'b0;
  logic [7:0] out_byte_o;
  logic       is_percent_o;
  logic       err_o;
  logic       err_kind_o;
  logic       out_last_o;

  escape_scoreboard sb;
  logic [7:0]       str_q[$];
  bit               calm = 1'b0;
  int unsigned      cycles = 0;
  int               stall_left = 0;

  escape_sequence_decoder DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_byte_i   (in_byte_i),
    .in_last_i   (in_last_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_byte_o  (out_byte_o),
    .is_percent_o(is_percent_o),
    .err_o       (err_o),
    .err_kind_o  (err_kind_o),
    .out_last_o  (out_last_o)
  );

  always #4 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Both channels are observed with the values they held just before the edge.
  always @(posedge clk_i) begin
    res_t got;
    if (rst_ni && sb != null) begin
      if (in_valid_i && !in_stall_o) sb.note_request(in_byte_i, in_last_i);
      if (out_valid_o && !out_stall_i) begin
        got.data = out_byte_o;
        got.pct  = is_percent_o;
        got.err  = err_o;
        got.kind = err_kind_o;
        got.last = out_last_o;
        sb.check_result(got);
      end
    end
  end

  always @(posedge clk_i) begin
    if (stall_left > 0) begin
      stall_left--;
    end else if (!calm && $urandom_range(0, 7) == 0) begin
      stall_left = $urandom_range(1, 18);
    end
    out_stall_i <= (stall_left > 0) && !calm;
  end

  task automatic send_string();
    int gap;
    foreach (str_q[i]) begin
      if (!calm && $urandom_range(0, 7) == 0) begin
        gap = $urandom_range(1, 18);
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      in_valid_i <= 1'b1;
      in_byte_i  <= str_q[i];
      in_last_i  <= (i == str_q.size() - 1);
      do @(posedge clk_i); while (in_stall_o);
    end
    str_q.delete();
  endtask

  function automatic logic [7:0] rand_hex_digit();
    case ($urandom_range(0, 2))
      0:       return 8'h30 + 8'($urandom_range(0, 9));
      1:       return 8'h61 + 8'($urandom_range(0, 5));
      default: return 8'h41 + 8'($urandom_range(0, 5));
    endcase
  endfunction

  function automatic logic [7:0] rand_named_char();
    case ($urandom_range(0, 11))
      0:       return 8'h22;
      1:       return 8'h27;
      2:       return CharBackslash;
      3:       return "a";
      4:       return "b";
      5:       return "e";
      6:       return "E";
      7:       return "f";
      8:       return "n";
      9:       return "r";
      10:      return "t";
      default: return "v";
    endcase
  endfunction

  // Mostly well-formed escapes with random content; about one piece in seven is broken.
  task automatic build_random_string();
    int         pieces;
    int         pick;
    int         n;
    logic [7:0] b;
    pieces = $urandom_range(1, 6);
    repeat (pieces) begin
      pick = $urandom_range(0, 99);
      if (pick < 35) begin
        if ($urandom_range(0, 7) == 0) begin
          b = CharPercent;
        end else begin
          do b = 8'($urandom_range(0, 255)); while (b == CharBackslash);
        end
        str_q.push_back(b);
      end else if (pick < 55) begin
        str_q.push_back(CharBackslash);
        str_q.push_back(rand_named_char());
      end else if (pick < 70) begin
        str_q.push_back(CharBackslash);
        n = $urandom_range(1, 3);
        repeat (n) str_q.push_back(8'h30 + 8'($urandom_range(0, 7)));
      end else if (pick < 85) begin
        str_q.push_back(CharBackslash);
        str_q.push_back(CharHexMark);
        n = $urandom_range(1, 2);
        repeat (n) str_q.push_back(rand_hex_digit());
      end else begin
        str_q.push_back(CharBackslash);
        case ($urandom_range(0, 2))
          0: str_q.push_back(8'($urandom_range(0, 255)));
          1: begin
            str_q.push_back(CharHexMark);
            str_q.push_back(8'($urandom_range(0, 255)));
          end
          default: ;
        endcase
      end
    end
  endtask

  initial begin
    sb = new();
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Plain extremes, a saturating octal escape and a hex value flushed by a percent sign.
    str_q = '{CharPercent, 8'h00, 8'hFF};
    send_string();
    str_q = '{CharBackslash, "7", "7", "7", "A"};
    send_string();
    str_q = '{CharBackslash, CharHexMark, "4", CharPercent};
    send_string();
    // Error cases: trailing backslash, bare \x, \x with no digit, escaped zero byte.
    str_q = '{CharBackslash};
    send_string();
    str_q = '{CharBackslash, CharHexMark};
    send_string();
    str_q = '{CharBackslash, CharHexMark, "z", "q"};
    send_string();
    str_q = '{CharBackslash, 8'h00};
    send_string();
    str_q = '{CharBackslash, "E", CharBackslash, "e"};
    send_string();

    while (sb.live < LiveTarget) begin
      if (sb.live >= CalmAfter) calm = 1'b1;
      build_random_string();
      send_string();
    end
    calm = 1'b1;
    in_valid_i <= 1'b0;

    @(posedge clk_i);
    while (sb.awaited.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    if (sb.mismatches == 0 && sb.awaited.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
